[rtl/pai_pkg.sv]
package pai_pkg;

  localparam int DEPTH    = 64;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 7;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rd;
    logic [IDX_W-1:0] idx;
  } cell_ctl_t;

endpackage

[rtl/pai_cell.sv]
module pai_cell
  import pai_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl_i,
  input  logic [IDX_W-1:0]  my_idx_i,
  input  logic [WORD_W-1:0] val_i,
  input  logic [WORD_W-1:0] left_i,
  input  logic [WORD_W-1:0] right_i,
  output logic [WORD_W-1:0] word_o,
  output logic [WORD_W-1:0] rd_o
);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctl_i.ins) begin
      if (my_idx_i > ctl_i.idx) begin
        word_nxt = left_i;
      end else if (my_idx_i == ctl_i.idx) begin
        word_nxt = val_i;
      end
    end else if (ctl_i.del) begin
      if (my_idx_i >= ctl_i.idx) begin
        word_nxt = right_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o = word_r;
  assign rd_o   = (ctl_i.rd && (my_idx_i == ctl_i.idx)) ? word_r : '0;

endmodule

[rtl/positional_array_insert_delete.sv]
// Channel   Direction  Handshake                 Payload
// in_       input      in_valid / in_stall       in_op, in_value, in_position
// out_      output     out_valid / out_stall     out_status, out_read_value, out_count
//
// One transaction per cycle unless stalled: every cell shifts, loads or holds
// in the same cycle, and the result is presented in the cycle after acceptance.
// Reset clears the live count and the output valid; cell contents are left as is.
// in_stall is high only while a result is held under out_stall.
module positional_array_insert_delete
  import pai_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_op,
  input  logic signed [31:0]  in_value,
  input  logic [6:0]          in_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_read_value,
  output logic [6:0]          out_count
);

  logic              acc;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r;
  logic [1:0]        status_r, status_nxt;
  logic [31:0]       rdval_r, rdval_nxt;
  logic [CMP_W-1:0]  pos_ext, cnt_ext;
  logic              pos_ok_ins, pos_ok_acc, full;
  logic [WORD_W-1:0] val_ext;
  cell_ctl_t         ctl;
  op_t               op;

  logic [WORD_W-1:0] words [DEPTH];
  logic [WORD_W-1:0] rds   [DEPTH];
  logic [WORD_W-1:0] rd_or;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign op       = op_t'(in_op);

  assign pos_ext    = CMP_W'(in_position);
  assign cnt_ext    = CMP_W'(count_r);
  assign full       = (count_r == CNT_W'(DEPTH));
  assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
  assign pos_ok_acc = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign val_ext    = WORD_W'(in_value);

  always_comb begin
    ctl.ins    = acc && (op == OP_INSERT) && !full && pos_ok_ins;
    ctl.del    = acc && (op == OP_DELETE) && pos_ok_acc;
    ctl.rd     = (op == OP_READ) && pos_ok_acc;
    ctl.idx    = IDX_W'(pos_ext - CMP_W'(1));
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_W-1:0] left_w, right_w;
      if (g == 0) begin : g_first
        assign left_w = words[g];
      end else begin : g_mid
        assign left_w = words[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_w = words[g];
      end else begin : g_inner
        assign right_w = words[g+1];
      end
      pai_cell u_cell (
        .clk      (clk),
        .ctl_i    (ctl),
        .my_idx_i (IDX_W'(g)),
        .val_i    (val_ext),
        .left_i   (left_w),
        .right_i  (right_w),
        .word_o   (words[g]),
        .rd_o     (rds[g])
      );
    end
  endgenerate

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | rds[i];
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rdval_nxt  = '0;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (!pos_ok_ins) begin
          status_nxt = ST_BAD_POS;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (!pos_ok_acc) begin
          status_nxt = ST_BAD_POS;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (!pos_ok_acc) begin
          status_nxt = ST_BAD_POS;
        end else begin
          rdval_nxt = 32'(rd_or);
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status_nxt;
      rdval_r  <= rdval_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_read_value = rdval_r;
  assign out_count      = 7'(count_r);

endmodule
